// ===== rtl/core/patt_pkg.sv =====
// Shared types, constants and helper functions for the pending-ack timeout table.
`timescale 1ns / 1ps

package patt_pkg;

  // Table geometry.
  localparam int SLOTS       = 8;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Command queue between the front and back ends.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [31:0] TIMEOUT_RESET = 32'd10000;

  // Input operation codes.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_ACK   = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_IGNORED = 3'd2,
    ST_ACKED   = 3'd3,
    ST_UNKNOWN = 3'd4,
    ST_TIMEOUT = 3'd5,
    ST_NONE    = 3'd6
  } patt_status_e;

  // Classified command handed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_ACK,
    CMD_CHECK,
    CMD_BAD
  } patt_cmd_e;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_EMIT
  } patt_state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] message_id;
    logic [31:0] now_tick;
  } patt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [15:0] entry_id;
    logic [31:0] elapsed_ticks;
    logic        last;
  } patt_out_t;

  typedef struct packed {
    patt_cmd_e   cmd;
    logic        id_zero;
    logic [15:0] message_id;
    logic [31:0] now_tick;
  } patt_cmd_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [SLOT_W-1:0] first_one(input logic [SLOTS-1:0] vec);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (vec[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

  // The slot field carries the low three bits of the slot index.
  function automatic logic [2:0] slot_field(input logic [SLOT_W-1:0] idx);
    logic [63:0] wide;
    wide = 64'(idx);
    return wide[2:0];
  endfunction

  function automatic patt_out_t make_result(input patt_status_e status,
                                            input logic [2:0]   slot,
                                            input logic [15:0]  entry_id,
                                            input logic [31:0]  elapsed,
                                            input logic         last);
    patt_out_t r;
    r.status        = status;
    r.slot          = slot;
    r.entry_id      = entry_id;
    r.elapsed_ticks = elapsed;
    r.last          = last;
    return r;
  endfunction

endpackage

// ===== rtl/core/patt_front.sv =====
// Front end: accepts input transactions, classifies them and queues the commands.
`timescale 1ns / 1ps

module patt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  patt_pkg::patt_in_t  in_data_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output patt_pkg::patt_cmd_t cmd_o
);

  patt_pkg::patt_cmd_t               q_mem [patt_pkg::QDEPTH];
  patt_pkg::patt_cmd_t               cls;
  logic [patt_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [patt_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [patt_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic                              push, pop;

  // Decode the operation into a command and flag the null id.
  always_comb begin
    cls.message_id = in_data_i.message_id;
    cls.now_tick   = in_data_i.now_tick;
    cls.id_zero    = (in_data_i.message_id == 16'd0);
    case (in_data_i.op)
      patt_pkg::OP_ADD:   cls.cmd = patt_pkg::CMD_ADD;
      patt_pkg::OP_ACK:   cls.cmd = patt_pkg::CMD_ACK;
      patt_pkg::OP_CHECK: cls.cmd = patt_pkg::CMD_CHECK;
      default:            cls.cmd = patt_pkg::CMD_BAD;
    endcase
  end

  assign in_ready_o  = (cnt_q != patt_pkg::QCNT_W'(patt_pkg::QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // Queue pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == patt_pkg::QPTR_W'(patt_pkg::QDEPTH - 1)) ? '0
                 : wr_ptr_q + patt_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == patt_pkg::QPTR_W'(patt_pkg::QDEPTH - 1)) ? '0
                 : rd_ptr_q + patt_pkg::QPTR_W'(1);
    end
    cnt_d = cnt_q + patt_pkg::QCNT_W'(push) - patt_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== rtl/core/patt_back.sv =====
// Back end: holds the slot table and carries out add, acknowledge and timeout checks.
`timescale 1ns / 1ps

module patt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  patt_pkg::patt_cmd_t cmd_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output patt_pkg::patt_out_t out_data_o
);

  patt_pkg::patt_state_e           state_q, state_d;
  logic [patt_pkg::SLOTS-1:0]      busy_q, busy_d;
  logic [patt_pkg::SLOTS-1:0]      exp_q, exp_d;
  logic [patt_pkg::SLOTS-1:0]      match_vec;
  logic [patt_pkg::SLOTS-1:0]      remaining;
  logic [15:0]                     msg_q [patt_pkg::SLOTS];
  logic [31:0]                     stamp_q [patt_pkg::SLOTS];
  logic [patt_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [patt_pkg::SLOT_W-1:0]     scan_idx_q, scan_idx_d;
  logic [patt_pkg::SLOT_W-1:0]     free_idx, ack_idx, emit_idx, rd_idx;
  logic [31:0]                     now_q, now_d;
  logic [31:0]                     timeout_q, timeout_d;
  logic [31:0]                     age, age_now;
  logic [15:0]                     rd_msg;
  logic                            have_free, have_match, out_free, wr_en, scan_last;
  logic                            out_valid_q, out_valid_d;
  patt_pkg::patt_out_t             out_q, out_d;

  // Parallel lookups over the table.
  always_comb begin
    for (int i = 0; i < patt_pkg::SLOTS; i++) begin
      match_vec[i] = busy_q[i] && (msg_q[i] == cmd_i.message_id);
    end
  end

  assign have_free  = |(~busy_q);
  assign have_match = |match_vec;
  assign free_idx   = patt_pkg::first_one(~busy_q);
  assign ack_idx    = patt_pkg::first_one(match_vec);
  assign emit_idx   = patt_pkg::first_one(exp_q);
  assign remaining  = exp_q & (exp_q - patt_pkg::SLOTS'(1));
  assign scan_last  = (scan_idx_q == patt_pkg::SLOT_W'(patt_pkg::SLOTS - 1));
  assign out_free   = !out_valid_q || out_ready_i;

  // One shared read port on the table, addressed by the current phase.
  always_comb begin
    case (state_q)
      patt_pkg::B_SCAN: rd_idx = scan_idx_q;
      patt_pkg::B_EMIT: rd_idx = emit_idx;
      default:          rd_idx = ack_idx;
    endcase
  end

  assign rd_msg  = msg_q[rd_idx];
  assign age_now = (state_q == patt_pkg::B_IDLE) ? cmd_i.now_tick : now_q;
  assign age     = age_now - stamp_q[rd_idx];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      patt_pkg::B_IDLE: begin
        if (cmd_valid_i && out_free && (cmd_i.cmd == patt_pkg::CMD_CHECK)) begin
          state_d = patt_pkg::B_SCAN;
        end
      end
      patt_pkg::B_SCAN: begin
        if (scan_last) state_d = patt_pkg::B_EMIT;
      end
      patt_pkg::B_EMIT: begin
        if (out_free && ((exp_q == '0) || (remaining == '0))) begin
          state_d = patt_pkg::B_IDLE;
        end
      end
      default: state_d = patt_pkg::B_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    busy_d      = busy_q;
    exp_d       = exp_q;
    cnt_d       = cnt_q;
    scan_idx_d  = scan_idx_q;
    now_d       = now_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    wr_en       = 1'b0;
    cmd_ready_o = 1'b0;
    timeout_d   = cfg_valid_i ? cfg_data_i : timeout_q;

    case (state_q)
      patt_pkg::B_IDLE: begin
        cmd_ready_o = out_free;
        if (cmd_valid_i && out_free) begin
          case (cmd_i.cmd)
            patt_pkg::CMD_ADD: begin
              out_valid_d = 1'b1;
              if (cmd_i.id_zero) begin
                out_d = patt_pkg::make_result(patt_pkg::ST_IGNORED, 3'd0,
                                              cmd_i.message_id, 32'd0, 1'b1);
              end else if (have_free) begin
                busy_d[free_idx] = 1'b1;
                wr_en            = 1'b1;
                out_d = patt_pkg::make_result(patt_pkg::ST_ADDED,
                                              patt_pkg::slot_field(free_idx),
                                              cmd_i.message_id, 32'd0, 1'b1);
              end else begin
                out_d = patt_pkg::make_result(patt_pkg::ST_FULL, 3'd0,
                                              cmd_i.message_id, 32'd0, 1'b1);
              end
            end
            patt_pkg::CMD_ACK: begin
              out_valid_d = 1'b1;
              if (!cmd_i.id_zero && have_match) begin
                busy_d[ack_idx] = 1'b0;
                out_d = patt_pkg::make_result(patt_pkg::ST_ACKED,
                                              patt_pkg::slot_field(ack_idx),
                                              cmd_i.message_id, age, 1'b1);
              end else begin
                out_d = patt_pkg::make_result(patt_pkg::ST_UNKNOWN, 3'd0,
                                              cmd_i.message_id, 32'd0, 1'b1);
              end
            end
            patt_pkg::CMD_CHECK: begin
              now_d      = cmd_i.now_tick;
              scan_idx_d = '0;
              cnt_d      = '0;
              exp_d      = '0;
            end
            default: begin
              out_valid_d = 1'b1;
              out_d = patt_pkg::make_result(patt_pkg::ST_IGNORED, 3'd0,
                                            cmd_i.message_id, 32'd0, 1'b1);
            end
          endcase
        end
      end
      // One slot per cycle: mark and free the expired ones, at most eight.
      patt_pkg::B_SCAN: begin
        if (busy_q[scan_idx_q] && (age >= timeout_q) &&
            (cnt_q < patt_pkg::CNT_W'(patt_pkg::MAX_RESULTS))) begin
          exp_d[scan_idx_q]  = 1'b1;
          busy_d[scan_idx_q] = 1'b0;
          cnt_d              = cnt_q + patt_pkg::CNT_W'(1);
        end
        if (!scan_last) scan_idx_d = scan_idx_q + patt_pkg::SLOT_W'(1);
      end
      // Report marked slots in ascending order, or a single none result.
      patt_pkg::B_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (exp_q == '0) begin
            out_d = patt_pkg::make_result(patt_pkg::ST_NONE, 3'd0, 16'd0, 32'd0, 1'b1);
          end else begin
            out_d = patt_pkg::make_result(patt_pkg::ST_TIMEOUT,
                                          patt_pkg::slot_field(emit_idx),
                                          rd_msg, age, (remaining == '0));
            exp_d = remaining;
          end
        end
      end
      default: ;
    endcase
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= patt_pkg::B_IDLE;
      busy_q      <= '0;
      exp_q       <= '0;
      cnt_q       <= '0;
      scan_idx_q  <= '0;
      out_valid_q <= 1'b0;
      timeout_q   <= patt_pkg::TIMEOUT_RESET;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      exp_q       <= exp_d;
      cnt_q       <= cnt_d;
      scan_idx_q  <= scan_idx_d;
      out_valid_q <= out_valid_d;
      timeout_q   <= timeout_d;
    end
  end

  // Payload registers and slot contents need no reset.
  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    out_q <= out_d;
    if (wr_en) begin
      msg_q[free_idx]   <= cmd_i.message_id;
      stamp_q[free_idx] <= cmd_i.now_tick;
    end
  end

  // A slot marked as expired has already been freed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_q & busy_q) == '0)
    else $error("expired slot still busy");

  // While scanning, the marked slots and the result count agree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == patt_pkg::B_SCAN) |-> ($countones(exp_q) == int'(cnt_q)))
    else $error("expiry mask and count disagree");

  // A stored add leaves its slot busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == patt_pkg::B_IDLE && cmd_valid_i && cmd_ready_o &&
     cmd_i.cmd == patt_pkg::CMD_ADD && !cmd_i.id_zero && have_free)
    |=> busy_q[$past(free_idx)])
    else $error("added slot not busy");

endmodule

// ===== rtl/core/pending_ack_timeout_table_core.sv =====
// Top level of the pending-ack timeout table: front end, command queue and back end.
`timescale 1ns / 1ps

// Tracks up to SLOTS messages awaiting acknowledgement. The front end takes one input
// transaction per cycle, while the queue has room, into a two-entry command queue;
// the back end executes them in order. Add, acknowledge and unused ops sustain one
// transaction per cycle while the output register drains. A check scans the table
// one slot per cycle through the shared table read port, then emits its results one
// per cycle as the output drains, up to eight timeouts or one none result. The timeout
// register resets to 10000 ticks and may be written only while the block is idle.

module pending_ack_timeout_table_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  patt_pkg::patt_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output patt_pkg::patt_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);

  logic                cmd_valid, cmd_ready;
  patt_pkg::patt_cmd_t cmd;

  patt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  patt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== dv/pending_ack_timeout_table_checker.sv =====
// Scoreboard for the pending-ack timeout table: tracks the slot table and checks every result.
`timescale 1ns / 1ps

module pending_ack_timeout_table_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  patt_pkg::patt_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  patt_pkg::patt_out_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [31:0]         cfg_data_i,
  output int                  outstanding_o,
  output int                  fail_count_o
);

  import patt_pkg::*;

  // Shadow copy of the slot table and the timeout register.
  logic        busy_q   [SLOTS];
  logic [15:0] ids_q    [SLOTS];
  logic [31:0] stamps_q [SLOTS];
  logic [31:0] timeout_q;

  // Results still owed by the block, oldest first.
  patt_out_t   owed_results [$];
  int          owed_cnt = 0;
  int          fail_cnt = 0;

  assign outstanding_o = owed_cnt;
  assign fail_count_o  = fail_cnt;

  function automatic patt_out_t table_reply(input patt_status_e st, input int idx,
                                            input logic [15:0] id, input logic [31:0] age);
    patt_out_t r;
    r.status        = st;
    r.slot          = 3'(idx);
    r.entry_id      = id;
    r.elapsed_ticks = age;
    r.last          = 1'b0;
    return r;
  endfunction

  // Applies one request to the shadow table and queues the results it should produce.
  task automatic apply_request(input patt_in_t req);
    patt_out_t   replies [$];
    logic [31:0] age;
    int          hit;
    hit = -1;
    case (req.op)
      OP_ADD: begin
        if (req.message_id == 16'd0) begin
          replies.push_back(table_reply(ST_IGNORED, 0, req.message_id, 32'd0));
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!busy_q[i] && hit < 0) hit = i;
          end
          if (hit >= 0) begin
            busy_q[hit]   = 1'b1;
            ids_q[hit]    = req.message_id;
            stamps_q[hit] = req.now_tick;
            replies.push_back(table_reply(ST_ADDED, hit, req.message_id, 32'd0));
          end else begin
            replies.push_back(table_reply(ST_FULL, 0, req.message_id, 32'd0));
          end
        end
      end
      OP_ACK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (busy_q[i] && ids_q[i] == req.message_id && hit < 0) hit = i;
        end
        if (req.message_id != 16'd0 && hit >= 0) begin
          busy_q[hit] = 1'b0;
          replies.push_back(table_reply(ST_ACKED, hit, req.message_id,
                                        req.now_tick - stamps_q[hit]));
        end else begin
          replies.push_back(table_reply(ST_UNKNOWN, 0, req.message_id, 32'd0));
        end
      end
      OP_CHECK: begin
        // Expired slots go out in ascending order, at most one burst's worth per check.
        for (int i = 0; i < SLOTS; i++) begin
          age = req.now_tick - stamps_q[i];
          if (busy_q[i] && age >= timeout_q && replies.size() < MAX_RESULTS) begin
            busy_q[i] = 1'b0;
            replies.push_back(table_reply(ST_TIMEOUT, i, ids_q[i], age));
          end
        end
        if (replies.size() == 0) begin
          replies.push_back(table_reply(ST_NONE, 0, 16'd0, 32'd0));
        end
      end
      default: begin
        replies.push_back(table_reply(ST_IGNORED, 0, req.message_id, 32'd0));
      end
    endcase
    replies[replies.size() - 1].last = 1'b1;
    foreach (replies[k]) owed_results.push_back(replies[k]);
  endtask

  // Watch all three channels at each edge and compare results against the oldest owed one.
  always @(posedge clk_i or negedge rst_ni) begin
    patt_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        busy_q[i]   = 1'b0;
        ids_q[i]    = 16'd0;
        stamps_q[i] = 32'd0;
      end
      timeout_q = TIMEOUT_RESET;
      owed_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) timeout_q = cfg_data_i;
      if (in_valid_i && in_ready_i) apply_request(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (owed_results.size() == 0) begin
          fail_cnt++;
          $error("result with none outstanding: status %0d slot %0d id %0h",
                 out_data_i.status, out_data_i.slot, out_data_i.entry_id);
        end else begin
          want = owed_results.pop_front();
          if (out_data_i.status !== want.status) begin
            fail_cnt++;
            $error("status: expected %0d, got %0d", want.status, out_data_i.status);
          end
          if (out_data_i.slot !== want.slot) begin
            fail_cnt++;
            $error("slot: expected %0d, got %0d", want.slot, out_data_i.slot);
          end
          if (out_data_i.entry_id !== want.entry_id) begin
            fail_cnt++;
            $error("entry_id: expected %0h, got %0h", want.entry_id, out_data_i.entry_id);
          end
          if (out_data_i.elapsed_ticks !== want.elapsed_ticks) begin
            fail_cnt++;
            $error("elapsed_ticks: expected %0h, got %0h", want.elapsed_ticks,
                   out_data_i.elapsed_ticks);
          end
          if (out_data_i.last !== want.last) begin
            fail_cnt++;
            $error("last: expected %0b, got %0b", want.last, out_data_i.last);
          end
        end
      end
    end
    owed_cnt = owed_results.size();
  end

endmodule

// ===== dv/pending_ack_timeout_table_core_tb.sv =====
// Testbench top for the pending-ack timeout table: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module pending_ack_timeout_table_core_tb;

  import patt_pkg::*;

  // Op code the block does not define; it must come back as ignored.
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          PHASE_ITEMS = 35;
  localparam int          PHASES      = 6;
  localparam logic [31:0] BASE_TICK   = 32'hFFFF_FF00;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  patt_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  patt_out_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;

  int          outstanding;
  int          fail_count;
  int          cycles = 0;
  logic        calm = 1'b0;
  logic        hold_req = 1'b0;
  logic [31:0] tick;

  pending_ack_timeout_table_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  pending_ack_timeout_table_checker scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_i    (out_data_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure, none in calm phases, and one long hold-off on request.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        for (int held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 31);
      end
    end
  end

  // Offers one request transaction and returns just after the edge that accepts it.
  task automatic offer_request(input logic [1:0] op, input logic [15:0] id,
                               input logic [31:0] now);
    patt_in_t req;
    logic     taken;
    req.op         = op;
    req.message_id = id;
    req.now_tick   = now;
    while (!calm && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Random request with a tick that moves at a pace matched to the current timeout.
  task automatic offer_random(input logic [31:0] limit);
    logic [31:0] span;
    logic [31:0] now;
    logic [15:0] id;
    logic [1:0]  op;
    int          pick;
    span = (limit > 32'd1_000_000) ? 32'd1_000_000 : limit;
    if ($urandom_range(99) < 5) tick += limit;
    else tick += $urandom_range(0, span / 3 + 1);

    // Mostly a small id pool so acknowledges find live entries.
    pick = $urandom_range(99);
    if (pick < 8) id = 16'd0;
    else if (pick < 75) id = 16'($urandom_range(1, 12));
    else id = 16'($urandom());

    pick = $urandom_range(99);
    if (pick < 40) op = OP_ADD;
    else if (pick < 70) op = OP_ACK;
    else if (pick < 95) op = OP_CHECK;
    else op = OP_UNUSED;

    // Ticks just behind the stamp give ages near the top of the 32-bit range.
    pick = $urandom_range(99);
    if (pick < 85) now = tick;
    else if (pick < 93) now = tick - $urandom_range(0, 2);
    else now = $urandom();
    offer_request(op, id, now);
  endtask

  // Stops offering and waits for every owed result to arrive.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [31:0] value);
    logic taken;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [31:0] limits [PHASES];
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset timeout: empty check, id zero, fill, full, duplicates.
    offer_request(OP_CHECK, 16'd0, BASE_TICK);
    offer_request(OP_ADD, 16'd0, BASE_TICK);
    offer_request(OP_ADD, 16'hFFFF, BASE_TICK);
    offer_request(OP_ADD, 16'd1, BASE_TICK + 32'd1);
    offer_request(OP_ADD, 16'd1, BASE_TICK + 32'd2);
    offer_request(OP_ADD, 16'h8000, BASE_TICK + 32'd3);
    offer_request(OP_ADD, 16'd5, BASE_TICK + 32'd4);
    offer_request(OP_ADD, 16'd6, BASE_TICK + 32'd5);
    offer_request(OP_ADD, 16'd7, BASE_TICK + 32'd6);
    offer_request(OP_ADD, 16'h00FF, BASE_TICK + 32'd7);
    offer_request(OP_ADD, 16'd9, BASE_TICK + 32'd8);
    // Unknown ids, then the duplicate id is freed lowest slot first.
    offer_request(OP_ACK, 16'd0, BASE_TICK + 32'd9);
    offer_request(OP_ACK, 16'h4321, BASE_TICK + 32'd9);
    offer_request(OP_ACK, 16'd1, BASE_TICK + 32'h20);
    offer_request(OP_ACK, 16'd1, BASE_TICK + 32'h40);
    offer_request(OP_UNUSED, 16'hABCD, 32'hFFFF_FFFF);
    offer_request(OP_CHECK, 16'h5555, BASE_TICK + 32'd100);
    // Refill across the tick wrap; then a full table expires in one burst of eight.
    offer_request(OP_ADD, 16'd2, 32'h0000_0010);
    offer_request(OP_ADD, 16'd3, 32'h0000_0020);
    offer_request(OP_CHECK, 16'd0, 32'd9000);
    offer_request(OP_CHECK, 16'd0, 32'd12000);
    offer_request(OP_ACK, 16'hFFFF, 32'd12001);
    offer_request(OP_ADD, 16'd3, 32'hFFFF_FFFF);
    offer_request(OP_ACK, 16'd3, 32'hFFFF_FFFF);
    offer_request(OP_CHECK, 16'd0, 32'd0);
    wait_drained();

    // Random phases, each under its own timeout; one holds the result side off for a while
    // and one runs with no idling on either side.
    limits[0] = 32'd1;
    limits[1] = 32'd300;
    limits[2] = 32'hFFFF_FFFF;
    limits[3] = TIMEOUT_RESET;
    limits[4] = $urandom_range(2, 5000);
    limits[5] = 32'd50;
    tick = $urandom();
    for (int p = 0; p < PHASES; p++) begin
      write_timeout(limits[p]);
      calm = (p == 4);
      if (p == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) offer_random(limits[p]);
      wait_drained();
    end
    calm = 1'b0;

    repeat (24) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
